@@ hdl/bsnc_pkg.sv @@
// Shared types and constants for the packed BCD sign nibble codec.
`default_nettype none

package bsnc_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned NibW    = 4;
  localparam int unsigned NumNib  = DataW / NibW;
  localparam int unsigned NumDig  = 20;
  localparam int unsigned BcdW    = NumDig * NibW;
  localparam int unsigned CntW    = 5;

  localparam logic [NibW-1:0] SignNib  = 4'hF;
  localparam logic [NibW-1:0] DigMax   = 4'd9;
  localparam logic [NibW-1:0] DabLimit = 4'd5;
  localparam logic [NibW-1:0] DabAdd   = 4'd3;

  typedef enum logic {
    OpEncode = 1'b0,
    OpDecode = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    Width8  = 2'd0,
    Width16 = 2'd1,
    Width32 = 2'd2,
    Width64 = 2'd3
  } width_e;

  // Payload that travels down the conversion pipeline.
  typedef struct packed {
    op_e              op;
    width_e           wc;
    logic             neg;
    logic             err;
    logic [DataW-1:0] src;
    logic [BcdW-1:0]  bcd;
    logic [DataW-1:0] acc;
  } stage_t;

endpackage

`default_nettype wire

@@ hdl/bsnc_step.sv @@
// One pipeline stage: four double-dabble shifts on encode, one decimal digit on decode.
`default_nettype none

module bsnc_step (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire bsnc_pkg::stage_t stage_i,
  output logic                  valid_o,
  output bsnc_pkg::stage_t      stage_o
);

  logic [bsnc_pkg::BcdW-1:0]  bcd_w;
  logic [bsnc_pkg::DataW-1:0] acc_w;
  bsnc_pkg::stage_t           stage_d;
  bsnc_pkg::stage_t           stage_q;
  logic                       valid_q;

  always_comb begin
    bcd_w = stage_i.bcd;
    for (int it = 0; it < bsnc_pkg::NibW; it++) begin
      for (int d = 0; d < bsnc_pkg::NumDig; d++) begin
        if (bcd_w[bsnc_pkg::NibW*d +: bsnc_pkg::NibW] >= bsnc_pkg::DabLimit) begin
          bcd_w[bsnc_pkg::NibW*d +: bsnc_pkg::NibW] =
            bcd_w[bsnc_pkg::NibW*d +: bsnc_pkg::NibW] + bsnc_pkg::DabAdd;
        end
      end
      bcd_w = {bcd_w[bsnc_pkg::BcdW-2:0], stage_i.src[bsnc_pkg::DataW-1-it]};
    end
  end

  // acc * 10 + next digit
  assign acc_w = {stage_i.acc[bsnc_pkg::DataW-4:0], 3'b000}
               + {stage_i.acc[bsnc_pkg::DataW-2:0], 1'b0}
               + {{(bsnc_pkg::DataW-bsnc_pkg::NibW){1'b0}},
                  stage_i.src[bsnc_pkg::DataW-1 -: bsnc_pkg::NibW]};

  always_comb begin
    stage_d     = stage_i;
    stage_d.src = {stage_i.src[bsnc_pkg::DataW-bsnc_pkg::NibW-1:0],
                   {bsnc_pkg::NibW{1'b0}}};
    unique case (stage_i.op)
      bsnc_pkg::OpEncode: stage_d.bcd = bcd_w;
      bsnc_pkg::OpDecode: stage_d.acc = acc_w;
      default:            stage_d.acc = acc_w;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

@@ hdl/bcd_sign_nibble_codec.sv @@
// Top level of the pipelined binary / packed BCD codec with sign nibble.
//
//   channel   ports                                             direction
//   command   start, busy (out), opcode_i, width_code_i,        in
//             signed_mode_i, value_i
//   result    valid_o, result_o, error_o                        out
//
// One command is taken every cycle; busy is never raised. A result passes
// through one input stage, sixteen digit stages (four binary bits or one
// BCD nibble each), a digit count stage and an output stage. The output
// strobes for one cycle and cannot be held off, so the pipeline never
// stalls. Reset clears only the valid bits.
`default_nettype none

module bcd_sign_nibble_codec (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode_i,
  input  wire logic [1:0]  width_code_i,
  input  wire logic        signed_mode_i,
  input  wire logic [63:0] value_i,
  output logic             valid_o,
  output logic [63:0]      result_o,
  output logic             error_o
);

  localparam int unsigned NumSteps = bsnc_pkg::NumNib;

  function automatic logic [bsnc_pkg::DataW-1:0] width_mask(bsnc_pkg::width_e wc);
    logic [bsnc_pkg::DataW-1:0] m;
    unique case (wc)
      bsnc_pkg::Width8:  m = 64'h0000_0000_0000_00FF;
      bsnc_pkg::Width16: m = 64'h0000_0000_0000_FFFF;
      bsnc_pkg::Width32: m = 64'h0000_0000_FFFF_FFFF;
      bsnc_pkg::Width64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default:           m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [bsnc_pkg::DataW-1:0] top_nib_mask(bsnc_pkg::width_e wc);
    logic [bsnc_pkg::DataW-1:0] m;
    unique case (wc)
      bsnc_pkg::Width8:  m = 64'h0000_0000_0000_00F0;
      bsnc_pkg::Width16: m = 64'h0000_0000_0000_F000;
      bsnc_pkg::Width32: m = 64'h0000_0000_F000_0000;
      bsnc_pkg::Width64: m = 64'hF000_0000_0000_0000;
      default:           m = 64'hF000_0000_0000_0000;
    endcase
    return m;
  endfunction

  function automatic logic [bsnc_pkg::CntW:0] nib_count(bsnc_pkg::width_e wc);
    logic [bsnc_pkg::CntW:0] n;
    unique case (wc)
      bsnc_pkg::Width8:  n = 6'd2;
      bsnc_pkg::Width16: n = 6'd4;
      bsnc_pkg::Width32: n = 6'd8;
      bsnc_pkg::Width64: n = 6'd16;
      default:           n = 6'd16;
    endcase
    return n;
  endfunction

  // ---------------- input stage ----------------
  logic                       accept;
  bsnc_pkg::width_e           wc_in;
  bsnc_pkg::op_e              op_in;
  logic [bsnc_pkg::DataW-1:0] mask_in;
  logic [bsnc_pkg::DataW-1:0] topm_in;
  logic [bsnc_pkg::DataW-1:0] masked;
  logic [bsnc_pkg::NibW-1:0]  top_nib;
  logic                       sign_bit;
  logic                       enc_neg;
  logic                       dec_neg;
  logic                       bad_nib;
  bsnc_pkg::stage_t           s0_d;
  bsnc_pkg::stage_t           s0_q;
  logic                       v0_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wc_in  = bsnc_pkg::width_e'(width_code_i);
  assign op_in  = bsnc_pkg::op_e'(opcode_i);

  always_comb begin
    mask_in = width_mask(wc_in);
    topm_in = top_nib_mask(wc_in);
    masked  = value_i & mask_in;
    unique case (wc_in)
      bsnc_pkg::Width8: begin
        sign_bit = masked[7];
        top_nib  = masked[7:4];
      end
      bsnc_pkg::Width16: begin
        sign_bit = masked[15];
        top_nib  = masked[15:12];
      end
      bsnc_pkg::Width32: begin
        sign_bit = masked[31];
        top_nib  = masked[31:28];
      end
      default: begin
        sign_bit = masked[63];
        top_nib  = masked[63:60];
      end
    endcase
    enc_neg = signed_mode_i && sign_bit;
    dec_neg = signed_mode_i && (top_nib == bsnc_pkg::SignNib);
    bad_nib = 1'b0;
    for (int i = 0; i < bsnc_pkg::NumNib; i++) begin
      // skip the sign nibble; nibbles above the width are already zero
      if ((masked[bsnc_pkg::NibW*i +: bsnc_pkg::NibW] > bsnc_pkg::DigMax)
          && !(dec_neg && topm_in[bsnc_pkg::NibW*i])) begin
        bad_nib = 1'b1;
      end
    end

    s0_d     = '0;
    s0_d.op  = op_in;
    s0_d.wc  = wc_in;
    unique case (op_in)
      bsnc_pkg::OpEncode: begin
        s0_d.neg = enc_neg;
        s0_d.err = 1'b0;
        s0_d.src = enc_neg ? ((~masked + 64'd1) & mask_in) : masked;
      end
      default: begin
        s0_d.neg = dec_neg;
        s0_d.err = bad_nib;
        s0_d.src = dec_neg ? (masked & ~topm_in) : masked;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
  end

  // ---------------- digit stages ----------------
  logic             step_v [NumSteps+1];
  bsnc_pkg::stage_t step_s [NumSteps+1];

  assign step_v[0] = v0_q;
  assign step_s[0] = s0_q;

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    bsnc_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (step_v[k]),
      .stage_i (step_s[k]),
      .valid_o (step_v[k+1]),
      .stage_o (step_s[k+1])
    );
  end

  // ---------------- digit count stage ----------------
  bsnc_pkg::stage_t           sl;
  logic [bsnc_pkg::CntW-1:0]  hi_dig;
  logic [bsnc_pkg::CntW-1:0]  cnt_d;
  logic [bsnc_pkg::CntW:0]    total;
  logic [bsnc_pkg::DataW-1:0] low_d;
  logic                       err_d;

  logic                       v1_q;
  bsnc_pkg::op_e              op1_q;
  bsnc_pkg::width_e           wc1_q;
  logic                       neg1_q;
  logic                       err1_q;
  logic [bsnc_pkg::CntW-1:0]  cnt1_q;
  logic [bsnc_pkg::DataW-1:0] low1_q;

  assign sl = step_s[NumSteps];

  always_comb begin
    hi_dig = '0;
    for (int d = 0; d < bsnc_pkg::NumDig; d++) begin
      if (sl.bcd[bsnc_pkg::NibW*d +: bsnc_pkg::NibW] != '0) begin
        hi_dig = bsnc_pkg::CntW'(d + 1);
      end
    end
    cnt_d = (hi_dig == '0) ? bsnc_pkg::CntW'(1) : hi_dig;
    total = {1'b0, cnt_d} + {{bsnc_pkg::CntW{1'b0}}, sl.neg};
    unique case (sl.op)
      bsnc_pkg::OpEncode: begin
        low_d = sl.bcd[bsnc_pkg::DataW-1:0];
        err_d = total > nib_count(sl.wc);
      end
      default: begin
        low_d = sl.neg ? (~sl.acc + 64'd1) : sl.acc;
        err_d = sl.err;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= step_v[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= sl.op;
    wc1_q  <= sl.wc;
    neg1_q <= sl.neg;
    err1_q <= err_d;
    cnt1_q <= cnt_d;
    low1_q <= low_d;
  end

  // ---------------- output stage ----------------
  logic [bsnc_pkg::DataW-1:0] sign_word;
  logic [bsnc_pkg::DataW-1:0] res_d;
  logic                       v2_q;
  logic [bsnc_pkg::DataW-1:0] res2_q;
  logic                       err2_q;

  always_comb begin
    // place the sign nibble just above the top digit, if it still lands in the word
    if (neg1_q && (cnt1_q < bsnc_pkg::CntW'(bsnc_pkg::NumNib))) begin
      sign_word = {{(bsnc_pkg::DataW-bsnc_pkg::NibW){1'b0}}, bsnc_pkg::SignNib}
                  << {cnt1_q[3:0], 2'b00};
    end else begin
      sign_word = '0;
    end
    unique case (op1_q)
      bsnc_pkg::OpEncode: res_d = (low1_q | sign_word) & width_mask(wc1_q);
      default:            res_d = err1_q ? '0 : (low1_q & width_mask(wc1_q));
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res2_q <= res_d;
    err2_q <= err1_q;
  end

  assign valid_o  = v2_q;
  assign result_o = res2_q;
  assign error_o  = err2_q;

endmodule

`default_nettype wire
